// ----- sv/vmt_pkg.sv -----
// Package for the 4x4 matrix-vector transform engine.
// Holds widths, fixed-point constants and the payload and lane types.
// No dependencies.
package vmt_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_COLS   = 4;
    localparam int COL_W      = 2;
    localparam int NUM_REGS   = 2 * NUM_COLS;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 2 * DATA_W;

    localparam logic signed [DATA_W-1:0] FIX_ONE = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
        logic signed [DATA_W-1:0] vec_w;
    } t_vec_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
        logic                     saturated;
    } t_vec_out;

    // Data handed from cell to cell: the vector and the running row sums.
    typedef struct packed {
        logic [NUM_COLS-1:0][DATA_W-1:0] vec;
        logic [NUM_ROWS-1:0][SUM_W-1:0]  sum;
    } t_lane;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// ----- sv/vmt_cell.sv -----
// One column cell of the transform chain: holds one matrix column,
// multiplies it by its vector component and adds into the row sums.
// Depends on vmt_pkg.
module vmt_cell import vmt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [COL_W-1:0] i_col,
    input  t_cfg_wr          i_cfg,
    input  logic             i_valid,
    input  t_lane            i_lane,
    output logic             o_ready,
    output logic             o_valid,
    output t_lane            o_lane,
    input  logic             i_ready
);

    logic signed [DATA_W-1:0] r_col [NUM_ROWS];

    logic                     r_a_valid;
    t_lane                    r_a_lane;
    logic signed [PROD_W-1:0] r_a_prod [NUM_ROWS];
    logic signed [PROD_W-1:0] n_prod   [NUM_ROWS];

    logic                     r_b_valid;
    t_lane                    r_b_lane;

    logic                     a_ready;
    logic                     b_ready;
    logic                     cfg_hit;
    logic signed [DATA_W-1:0] comp;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_valid;
    assign o_lane  = r_b_lane;

    assign cfg_hit = i_cfg.en && (i_cfg.index < CFG_IDX_W'(NUM_REGS))
                     && (i_cfg.index[COL_W:1] == i_col);

    always_comb begin
        comp = $signed(i_lane.vec[i_col]);
        for (int r = 0; r < NUM_ROWS; r++) begin
            n_prod[r] = PROD_W'(r_col[r]) * PROD_W'(comp);
        end
    end

    // Column storage; reset loads the identity column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_col[r] <= (COL_W'(r) == i_col) ? FIX_ONE : '0;
            end
        end else if (cfg_hit) begin
            if (!i_cfg.index[0]) begin
                r_col[0] <= i_cfg.data[DATA_W-1:0];
                r_col[1] <= i_cfg.data[CFG_DATA_W-1:DATA_W];
            end else begin
                r_col[2] <= i_cfg.data[DATA_W-1:0];
                r_col[3] <= i_cfg.data[CFG_DATA_W-1:DATA_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // Multiply stage, then accumulate stage.
    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_lane <= i_lane;
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_a_prod[r] <= n_prod[r];
            end
        end
        if (b_ready && r_a_valid) begin
            r_b_lane.vec <= r_a_lane.vec;
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_b_lane.sum[r] <= $signed(r_a_lane.sum[r])
                                   + $signed({{(SUM_W-PROD_W){r_a_prod[r][PROD_W-1]}},
                                              r_a_prod[r]});
            end
        end
    end

endmodule

// ----- sv/vmt_sat.sv -----
// Output cell: shifts the row sums down to Q16.16, saturates them and
// holds the finished transaction in the output register. Depends on vmt_pkg.
module vmt_sat import vmt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_lane    i_lane,
    output logic     o_ready,
    output logic     o_valid,
    output t_vec_out o_data,
    input  logic     i_stall
);

    logic                     r_valid;
    t_vec_out                 r_data;
    t_vec_out                 n_data;
    logic                     ready;
    logic signed [SUM_W-1:0]  shifted [NUM_ROWS];
    logic signed [DATA_W-1:0] res     [NUM_ROWS];
    logic [NUM_ROWS-1:0]      clip;

    assign ready   = !r_valid || !i_stall;
    assign o_ready = ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            shifted[r] = $signed(i_lane.sum[r]) >>> FRAC_BITS;
            // In range when every bit above the result width copies its sign.
            clip[r] = !((&shifted[r][SUM_W-1:DATA_W-1]) ||
                        !(|shifted[r][SUM_W-1:DATA_W-1]));
            if (!clip[r]) begin
                res[r] = shifted[r][DATA_W-1:0];
            end else if (shifted[r][SUM_W-1]) begin
                res[r] = SAT_MIN;
            end else begin
                res[r] = SAT_MAX;
            end
        end
        n_data.out_x     = res[0];
        n_data.out_y     = res[1];
        n_data.out_z     = res[2];
        n_data.out_w     = res[3];
        n_data.saturated = |clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- sv/vec4_matrix_transform_top.sv -----
// Top level of the 4x4 matrix-vector transform engine (result = M * v, Q16.16).
// 9 registers lie between an accepted vector and its result: the chain of four column
// cells (one multiply stage and one add stage each) and the saturating output register.
// Throughput: one vector per cycle while the result channel is not stalled.
// Reset (synchronous, active low) empties the chain and loads the identity matrix.
// Depends on vmt_pkg, vmt_cell and vmt_sat.
module vec4_matrix_transform_top import vmt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input vector channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_vec_in               i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_vec_out              o_out_data,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Chain links: link c feeds cell c, link NUM_COLS feeds the output cell.
    logic  link_valid [NUM_COLS+1];
    logic  link_ready [NUM_COLS+1];
    t_lane link_lane  [NUM_COLS+1];

    t_cfg_wr cfg;

    // Configuration writes go straight into the column storage registers; always take them.
    assign o_cfg_ready = 1'b1;
    assign cfg.en      = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    // Launch a transaction into the first cell with zeroed row sums.
    assign link_valid[0]      = i_in_valid;
    assign link_lane[0].vec[0] = i_in_data.vec_x;
    assign link_lane[0].vec[1] = i_in_data.vec_y;
    assign link_lane[0].vec[2] = i_in_data.vec_z;
    assign link_lane[0].vec[3] = i_in_data.vec_w;
    assign link_lane[0].sum    = '0;

    // Stall the source only when the first stage is full and cannot advance;
    // bubbles anywhere in the chain still absorb new vectors.
    assign o_in_stall = !link_ready[0];

    // Each cell owns one matrix column and adds its column times v[c]
    // into the running sums before handing them to the next cell.
    for (genvar g = 0; g < NUM_COLS; g++) begin : g_cell
        vmt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_col   (COL_W'(g)),
            .i_cfg   (cfg),
            .i_valid (link_valid[g]),
            .i_lane  (link_lane[g]),
            .o_ready (link_ready[g]),
            .o_valid (link_valid[g+1]),
            .o_lane  (link_lane[g+1]),
            .i_ready (link_ready[g+1])
        );
    end

    // Drop the fraction bits, clip to 32 bits and hold the result until taken.
    vmt_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (link_valid[NUM_COLS]),
        .i_lane  (link_lane[NUM_COLS]),
        .o_ready (link_ready[NUM_COLS]),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule
